// ----- sv/present_pkg.sv -----
// ----------------------------------------------------------------------------
// present_pkg
// Shared types, constants and round functions for the PRESENT encrypt pipeline.
// ----------------------------------------------------------------------------
package present_pkg;

  localparam int unsigned NumRoundKeysDef = 32;
  localparam int unsigned BlockW          = 64;
  localparam int unsigned KeyHalfW        = 64;
  localparam int unsigned CtrW            = 5;
  localparam int unsigned CfgIdxW         = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgKeyUpper = 2'd0,
    CfgKeyLower = 2'd1,
    CfgKeyMode  = 2'd2,
    CfgUnused   = 2'd3
  } cfg_idx_e;

  // One pipeline slot: valid, schedule mode, cipher state and key register.
  typedef struct packed {
    logic                vld;
    logic                wide;
    logic [BlockW-1:0]   st;
    logic [KeyHalfW-1:0] hi;
    logic [KeyHalfW-1:0] lo;
  } pres_lane_t;

  function automatic logic [3:0] sbox4(input logic [3:0] x);
    logic [3:0] y;
    unique case (x)
      4'h0: y = 4'hc;
      4'h1: y = 4'h5;
      4'h2: y = 4'h6;
      4'h3: y = 4'hb;
      4'h4: y = 4'h9;
      4'h5: y = 4'h0;
      4'h6: y = 4'ha;
      4'h7: y = 4'hd;
      4'h8: y = 4'h3;
      4'h9: y = 4'he;
      4'ha: y = 4'hf;
      4'hb: y = 4'h8;
      4'hc: y = 4'h4;
      4'hd: y = 4'h7;
      4'he: y = 4'h1;
      4'hf: y = 4'h2;
      default: y = 4'h0;
    endcase
    return y;
  endfunction

  function automatic logic [BlockW-1:0] sub_nibbles(input logic [BlockW-1:0] x);
    logic [BlockW-1:0] y;
    y = '0;
    for (int n = 0; n < BlockW / 4; n++) begin
      y[4*n +: 4] = sbox4(x[4*n +: 4]);
    end
    return y;
  endfunction

  // Bit b moves to (b mod 4) * 16 + b / 4.
  function automatic logic [BlockW-1:0] permute_bits(input logic [BlockW-1:0] x);
    logic [BlockW-1:0] y;
    y = '0;
    for (int b = 0; b < BlockW; b++) begin
      y[(b % 4) * 16 + b / 4] = x[b];
    end
    return y;
  endfunction

  function automatic logic [BlockW-1:0] round_key(input logic                wide,
                                                  input logic [KeyHalfW-1:0] hi,
                                                  input logic [KeyHalfW-1:0] lo);
    logic [BlockW-1:0] rk;
    rk = wide ? hi : {hi[15:0], lo[63:16]};
    return rk;
  endfunction

endpackage

// ----- sv/present_block_encrypt.sv -----
// ----------------------------------------------------------------------------
// present_block_encrypt
// PRESENT block encryption, one register stage per round, 80/128-bit keys.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Payload
// input     in         start_i / busy_o   plaintext_i
// result    out        done_o (strobe)    ciphertext_o
// config    in         cfg_we_i           cfg_idx_i, cfg_wdata_i
//
// An item enters on every cycle with start_i high; busy_o is always low.
// Each item passes one register stage per round plus the registered final key add.
// The key schedule travels down the pipeline with each item.
// Reset clears the key registers and all valid bits; results are not held.
// ----------------------------------------------------------------------------
module present_block_encrypt #(
  parameter int unsigned NumRoundKeys = present_pkg::NumRoundKeysDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [present_pkg::BlockW-1:0]     plaintext_i,
  output logic                               done_o,
  output logic [present_pkg::BlockW-1:0]     ciphertext_o,
  input  logic                               cfg_we_i,
  input  logic [present_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [present_pkg::KeyHalfW-1:0]   cfg_wdata_i
);
  import present_pkg::*;

  localparam int unsigned NumRounds = NumRoundKeys - 1;

  logic [KeyHalfW-1:0] key_upper_q, key_lower_q;
  logic                key_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_upper_q <= '0;
      key_lower_q <= '0;
      key_mode_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgKeyUpper: key_upper_q <= cfg_wdata_i;
        CfgKeyLower: key_lower_q <= cfg_wdata_i;
        CfgKeyMode:  key_mode_q  <= cfg_wdata_i[0];
        CfgUnused:   ;
        default:     ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  pres_lane_t lane [NumRounds+1];

  always_comb begin
    lane[0].vld  = start_i & ~busy_o;
    lane[0].wide = key_mode_q;
    lane[0].st   = plaintext_i;
    lane[0].hi   = key_mode_q ? key_upper_q : {48'd0, key_upper_q[15:0]};
    lane[0].lo   = key_lower_q;
  end

  for (genvar r = 0; r < NumRounds; r++) begin : g_round
    present_round #(
      .Round(r)
    ) u_round (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .lane_i(lane[r]),
      .lane_o(lane[r+1])
    );
  end

  logic              done_q;
  logic [BlockW-1:0] ct_d, ct_q;

  assign ct_d = lane[NumRounds].st ^
                round_key(lane[NumRounds].wide, lane[NumRounds].hi, lane[NumRounds].lo);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= lane[NumRounds].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    ct_q <= ct_d;
  end

  assign done_o       = done_q;
  assign ciphertext_o = ct_q;

endmodule

// ----- sv/present_round.sv -----
// ----------------------------------------------------------------------------
// present_round
// One registered cipher round: key add, S-box layer, bit permutation, and
// the matching 80/128-bit key schedule step.
// ----------------------------------------------------------------------------
module present_round #(
  parameter int unsigned Round = 0
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  present_pkg::pres_lane_t lane_i,
  output present_pkg::pres_lane_t lane_o
);
  import present_pkg::*;

  localparam logic [CtrW-1:0] Ctr = CtrW'(Round + 1);

  pres_lane_t lane_d;

  logic                vld_q;
  logic                wide_q;
  logic [BlockW-1:0]   st_q;
  logic [KeyHalfW-1:0] hi_q, lo_q;

  logic [KeyHalfW-1:0] nh_w, nl_w, nh_n, nl_n;

  always_comb begin
    // 128-bit schedule
    nh_w          = {lane_i.hi[2:0], lane_i.lo[63:3]};
    nl_w          = {lane_i.lo[2:0], lane_i.hi[63:3]};
    nh_w[63:60]   = sbox4(nh_w[63:60]);
    nh_w[59:56]   = sbox4(nh_w[59:56]);
    nh_w[2:0]     = nh_w[2:0] ^ Ctr[4:2];
    nl_w[63:62]   = nl_w[63:62] ^ Ctr[1:0];
    // 80-bit schedule, upper part kept in hi[15:0]
    nh_n          = {48'd0, lane_i.lo[18:3]};
    nh_n[15:12]   = sbox4(nh_n[15:12]);
    nl_n          = {lane_i.lo[2:0], lane_i.hi[15:0], lane_i.lo[63:19]};
    nl_n[19:15]   = nl_n[19:15] ^ Ctr;

    lane_d.vld  = lane_i.vld;
    lane_d.wide = lane_i.wide;
    lane_d.st   = permute_bits(sub_nibbles(lane_i.st ^
                                           round_key(lane_i.wide, lane_i.hi, lane_i.lo)));
    lane_d.hi   = lane_i.wide ? nh_w : nh_n;
    lane_d.lo   = lane_i.wide ? nl_w : nl_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= lane_d.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    wide_q <= lane_d.wide;
    st_q   <= lane_d.st;
    hi_q   <= lane_d.hi;
    lo_q   <= lane_d.lo;
  end

  assign lane_o = '{vld: vld_q, wide: wide_q, st: st_q, hi: hi_q, lo: lo_q};

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Bench for present_block_encrypt. Plaintext items go in with random gaps,
// each ciphertext is checked against a cycle-free model of the cipher. Keys
// and schedule mode change between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_top;
  import present_pkg::*;

  localparam int unsigned ROUNDS         = NumRoundKeysDef;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  // 4-bit S-box, entry n in nibble n
  localparam logic [63:0] SBOX_TAB       = 64'h21748fe3da09b65c;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [BlockW-1:0]   plaintext_i;
  logic                done_o;
  logic [BlockW-1:0]   ciphertext_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [KeyHalfW-1:0] cfg_wdata_i;

  logic [KeyHalfW-1:0] key_hi_q;
  logic [KeyHalfW-1:0] key_lo_q;
  logic                key_wide_q;
  logic [BlockW-1:0]   exp_cipher_q[$];
  int                  mismatch_cnt;
  int                  idle_cycles;
  bit                  idle_on;

  present_block_encrypt #(
    .NumRoundKeys(ROUNDS)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .plaintext_i (plaintext_i),
    .done_o      (done_o),
    .ciphertext_o(ciphertext_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [3:0] sbox_nib(input logic [3:0] x);
    return SBOX_TAB[4*x +: 4];
  endfunction

  function automatic logic [63:0] encrypt_block(input logic [63:0] pt,
                                                input logic [63:0] ku,
                                                input logic [63:0] kl,
                                                input logic        wide);
    logic [63:0] st;
    logic [63:0] sb;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [63:0] nh;
    logic [63:0] nl;
    logic [4:0]  ctr;
    int          r;
    int          n;
    int          b;
    hi = wide ? ku : {48'b0, ku[15:0]};
    lo = kl;
    st = pt;
    for (r = 1; r < ROUNDS; r++) begin
      st = st ^ (wide ? hi : {hi[15:0], lo[63:16]});
      for (n = 0; n < 16; n++) begin
        sb[4*n +: 4] = sbox_nib(st[4*n +: 4]);
      end
      for (b = 0; b < 64; b++) begin
        st[(b % 4) * 16 + b / 4] = sb[b];
      end
      ctr = r[4:0];
      if (wide) begin
        // 128-bit register rotated left by 61, two S-boxes, counter split
        nh = {hi[2:0], lo[63:3]};
        nl = {lo[2:0], hi[63:3]};
        nh[63:60] = sbox_nib(nh[63:60]);
        nh[59:56] = sbox_nib(nh[59:56]);
        nh[2:0]   = nh[2:0] ^ ctr[4:2];
        nl[63:62] = nl[63:62] ^ ctr[1:0];
      end else begin
        // 80-bit register rotated left by 61, top nibble through S-box
        nh = {48'b0, lo[18:3]};
        nl = {lo[2:0], hi[15:0], lo[63:19]};
        nh[15:12] = sbox_nib(nh[15:12]);
        nl[19:15] = nl[19:15] ^ ctr;
      end
      hi = nh;
      lo = nl;
    end
    return st ^ (wide ? hi : {hi[15:0], lo[63:16]});
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_block();
    case ($urandom_range(0, 7))
      0: return 64'h1 << $urandom_range(0, 63);
      1: return ~(64'h1 << $urandom_range(0, 63));
      default: return rand_word();
    endcase
  endfunction

  // ciphertext check
  always @(posedge clk_i) begin : check_results
    logic [BlockW-1:0] want;
    if (rst_ni && done_o) begin
      if (exp_cipher_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected ciphertext %h", ciphertext_o);
      end else begin
        want = exp_cipher_q.pop_front();
        if (ciphertext_o !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("ciphertext mismatch: expected %h got %h", want, ciphertext_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o || cfg_we_i) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  task automatic drain();
    start_i <= 1'b0;
    while (exp_cipher_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [63:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CfgKeyUpper: key_hi_q = val;
      CfgKeyLower: key_lo_q = val;
      CfgKeyMode: key_wide_q = val[0];
      default: ;
    endcase
  endtask

  task automatic load_key(input logic [63:0] ku, input logic [63:0] kl,
                          input logic [63:0] mode, input bit poke_unused);
    drain();
    write_reg(CfgKeyUpper, ku);
    write_reg(CfgKeyLower, kl);
    write_reg(CfgKeyMode, mode);
    if (poke_unused) write_reg(CfgUnused, rand_word());
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_block(input logic [63:0] pt);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i     <= 1'b1;
    plaintext_i <= pt;
    do @(posedge clk_i); while (busy_o);
    exp_cipher_q.push_back(encrypt_block(pt, key_hi_q, key_lo_q, key_wide_q));
  endtask

  // key registers come out of reset as zero, 80-bit schedule
  task automatic test_reset_key();
    idle_on = 1'b0;
    send_block(64'h0);
    send_block('1);
    send_block(64'h0123_4567_89ab_cdef);
  endtask

  // upper key bits above 79 must not matter
  task automatic test_key_80();
    load_key('1, '1, 64'h0, 1'b0);
    send_block(64'h0);
    send_block('1);
    load_key(64'hffff_ffff_ffff_0000, 64'h0, 64'h0, 1'b0);
    send_block(64'h0);
    send_block(64'h8000_0000_0000_0001);
  endtask

  // only bit 0 of the mode write counts
  task automatic test_key_128();
    load_key('1, '1, '1, 1'b0);
    send_block(64'h0);
    send_block('1);
    load_key(64'h0, 64'h0, 64'h1, 1'b0);
    send_block(64'h0);
    send_block(64'haaaa_aaaa_aaaa_aaaa);
    load_key(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
             64'hffff_ffff_ffff_fffe, 1'b0);
    send_block(64'h5555_5555_5555_5555);
  endtask

  // a write to the spare index leaves the key alone
  task automatic test_unknown_index();
    load_key(rand_word(), rand_word(), rand_word(), 1'b1);
    send_block('1);
    send_block(64'h0);
  endtask

  task automatic test_random_phases(input int phases);
    int p;
    int i;
    int cnt;
    logic [63:0] ku;
    logic [63:0] kl;
    for (p = 0; p < phases; p++) begin
      case ($urandom_range(0, 5))
        0: ku = '0;
        1: ku = '1;
        default: ku = rand_word();
      endcase
      case ($urandom_range(0, 5))
        0: kl = '0;
        1: kl = '1;
        default: kl = rand_word();
      endcase
      load_key(ku, kl, rand_word(), $urandom_range(0, 3) == 0);
      idle_on = $urandom_range(0, 3) != 0;
      cnt = $urandom_range(20, 100);
      for (i = 0; i < cnt; i++) begin
        send_block(rand_block());
      end
    end
  endtask

  // back-to-back items, pipeline full
  task automatic test_streaming(input int cnt);
    int i;
    load_key(rand_word(), rand_word(), rand_word(), 1'b0);
    idle_on = 1'b0;
    for (i = 0; i < cnt; i++) begin
      send_block(rand_block());
    end
  endtask

  initial begin
    mismatch_cnt = 0;
    idle_cycles  = 0;
    idle_on      = 1'b0;
    key_hi_q     = '0;
    key_lo_q     = '0;
    key_wide_q   = 1'b0;
    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    plaintext_i <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CfgKeyUpper;
    cfg_wdata_i <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_key();
    test_key_80();
    test_key_128();
    test_unknown_index();
    test_random_phases(24);
    test_streaming(100);

    drain();
    repeat (ROUNDS + 8) @(posedge clk_i);
    if (mismatch_cnt == 0 && exp_cipher_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ----- present_block_encrypt.f -----
sv/present_pkg.sv
sv/present_round.sv
sv/present_block_encrypt.sv
bench/tb_top.sv
